// ----- rtl/apq_pkg.sv -----
// Shared types, widths and helpers for the array priority queue.
package apq_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VAL_W    = 32;
   localparam int PRI_W    = 16;
   localparam int STATUS_W = 2;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_MOVE,
      FSM_SCAN,
      FSM_DONE
   } fsm_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic signed [PRI_W-1:0] prio;
   } entry_type;

   // True when entry a is served before entry b: priority first, then value.
   function automatic logic outranks(entry_type a, entry_type b);
      logic result;
      if (a.prio != b.prio) begin
         result = (a.prio > b.prio);
      end else begin
         result = (a.value > b.value);
      end
      return result;
   endfunction

endpackage

// ----- rtl/apq_ifs.sv -----
// Request and response channel interfaces of the array priority queue.
interface apq_req_if;
   logic                               valid;
   logic                               ready;
   logic                               opcode;
   logic signed [apq_pkg::VAL_W-1:0]   entry_value;
   logic signed [apq_pkg::PRI_W-1:0]   entry_priority;

   modport source (output valid, output opcode, output entry_value,
                   output entry_priority, input ready);
   modport sink   (input valid, input opcode, input entry_value,
                   input entry_priority, output ready);
endinterface

interface apq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [apq_pkg::STATUS_W-1:0]       status;
   logic signed [apq_pkg::VAL_W-1:0]   removed_value;
   logic signed [apq_pkg::PRI_W-1:0]   removed_priority;
   logic [apq_pkg::CNT_W-1:0]          count_after;
   logic                               top_valid;
   logic signed [apq_pkg::VAL_W-1:0]   top_value;
   logic signed [apq_pkg::PRI_W-1:0]   top_priority;

   modport source (output valid, output status, output removed_value,
                   output removed_priority, output count_after, output top_valid,
                   output top_value, output top_priority, input ready);
   modport sink   (input valid, input status, input removed_value,
                   input removed_priority, input count_after, input top_valid,
                   input top_value, input top_priority, output ready);
endinterface

// ----- rtl/array_priority_queue.sv -----
// Array priority queue: unsorted entry memory with a registered top entry.
//
// Bounded queue of up to 64 (value, priority) entries held unsorted in one
// single-port-write, registered-read memory. An insert writes the new entry
// at the end of the array and compares it with the registered top entry; the
// result is loaded into the output register from the done state. A remove
// reports the top entry, fills its slot with the last entry and then rescans
// the remaining entries, one memory read per cycle, to find the new top; it
// skips the rescan when it empties the queue. A remove on an empty queue or an
// insert on a full one is reported by its status and changes nothing. A
// finished result sits in an output register, so a new request is taken
// while it waits. A request that finishes while that register is still
// occupied holds the block until the waiting response is taken.
module array_priority_queue (
   input  logic        clock,
   input  logic        reset,
   apq_req_if.sink     req_ch,
   apq_rsp_if.source   rsp_ch
);
   import apq_pkg::*;

   // Entry store
   entry_type               mem [CAPACITY];
   logic                    mem_we;
   logic [IDX_W-1:0]        mem_waddr;
   entry_type               mem_wdata;
   logic                    mem_re;
   logic [IDX_W-1:0]        mem_raddr;
   entry_type               rd_data_ff;

   // Control and working state
   fsm_type                 state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    top_valid_ff, top_valid_in;
   entry_type               top_entry_ff, top_entry_in;
   logic [IDX_W-1:0]        top_idx_ff, top_idx_in;
   status_type              status_ff, status_in;
   entry_type               removed_ff, removed_in;
   logic [CNT_W-1:0]        scan_addr_ff, scan_addr_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]        rd_idx_ff, rd_idx_in;

   // Output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_load;
   status_type              rsp_status_ff;
   entry_type               rsp_removed_ff;
   logic [CNT_W-1:0]        rsp_count_ff;
   logic                    rsp_top_valid_ff;
   entry_type               rsp_top_ff;

   entry_type               req_entry;
   logic [CNT_W-1:0]        count_less_one;

   assign req_entry      = {req_ch.entry_value, req_ch.entry_priority};
   assign count_less_one = count_ff - CNT_W'(1);

   assign req_ch.ready = (state_ff == FSM_IDLE);

   // Memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   // Next state, memory access and datapath updates
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      top_valid_in = top_valid_ff;
      top_entry_in = top_entry_ff;
      top_idx_in   = top_idx_ff;
      status_in    = status_ff;
      removed_in   = removed_ff;
      scan_addr_in = scan_addr_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      mem_we       = 1'b0;
      mem_waddr    = count_ff[IDX_W-1:0];
      mem_wdata    = req_entry;
      mem_re       = 1'b0;
      mem_raddr    = count_less_one[IDX_W-1:0];
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff;

      // Drop the shown result once taken
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         FSM_IDLE: begin
            if (req_ch.valid) begin
               status_in  = STATUS_OK;
               removed_in = '0;
               state_in   = FSM_DONE;
               if (req_ch.opcode == OP_INSERT) begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                  end else begin
                     // Append the entry and fold it into the top
                     mem_we   = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                     top_valid_in = 1'b1;
                     if (!top_valid_ff || outranks(req_entry, top_entry_ff)) begin
                        top_entry_in = req_entry;
                        top_idx_in   = count_ff[IDX_W-1:0];
                     end
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     // Report the top and fetch the last entry to fill its slot
                     removed_in = top_entry_ff;
                     mem_re     = 1'b1;
                     state_in   = FSM_MOVE;
                  end
               end
            end
         end
         FSM_MOVE: begin
            mem_we       = 1'b1;
            mem_waddr    = top_idx_ff;
            mem_wdata    = rd_data_ff;
            count_in     = count_less_one;
            scan_addr_in = '0;
            if (count_less_one == '0) begin
               top_valid_in = 1'b0;
               state_in     = FSM_DONE;
            end else begin
               state_in = FSM_SCAN;
            end
         end
         FSM_SCAN: begin
            // Compare the entry read last cycle with the best so far
            if (rd_vld_ff) begin
               if (rd_idx_ff == '0 || outranks(rd_data_ff, top_entry_ff)) begin
                  top_entry_in = rd_data_ff;
                  top_idx_in   = rd_idx_ff;
               end
            end
            // Issue the next read, or finish once the last compare is done
            if (scan_addr_ff < count_ff) begin
               mem_re       = 1'b1;
               mem_raddr    = scan_addr_ff[IDX_W-1:0];
               rd_vld_in    = 1'b1;
               rd_idx_in    = scan_addr_ff[IDX_W-1:0];
               scan_addr_in = scan_addr_ff + CNT_W'(1);
            end else if (!rd_vld_ff) begin
               state_in = FSM_DONE;
            end
         end
         FSM_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         top_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         top_valid_ff <= top_valid_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      top_entry_ff <= top_entry_in;
      top_idx_ff   <= top_idx_in;
      status_ff    <= status_in;
      removed_ff   <= removed_in;
      scan_addr_ff <= scan_addr_in;
      rd_idx_ff    <= rd_idx_in;
      if (rsp_load) begin
         rsp_status_ff    <= status_ff;
         rsp_removed_ff   <= removed_ff;
         rsp_count_ff     <= count_ff;
         rsp_top_valid_ff <= top_valid_ff;
         rsp_top_ff       <= top_valid_ff ? top_entry_ff : '0;
      end
   end

   // Drive the response channel
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.status           = rsp_status_ff;
   assign rsp_ch.removed_value    = rsp_removed_ff.value;
   assign rsp_ch.removed_priority = rsp_removed_ff.prio;
   assign rsp_ch.count_after      = rsp_count_ff;
   assign rsp_ch.top_valid        = rsp_top_valid_ff;
   assign rsp_ch.top_value        = rsp_top_ff.value;
   assign rsp_ch.top_priority     = rsp_top_ff.prio;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the array priority queue.
`timescale 1ns / 1ps

module testbench;
   import apq_pkg::*;

   localparam int ITEM_TARGET = 1450;
   localparam int DRAIN_CYCLES = 100;
   localparam int PRINT_LIMIT = 40;

   // One expected or observed response of the queue
   typedef struct packed {
      status_type                status;
      logic signed [VAL_W-1:0]   removed_value;
      logic signed [PRI_W-1:0]   removed_priority;
      logic [CNT_W-1:0]          count_after;
      logic                      top_valid;
      logic signed [VAL_W-1:0]   top_value;
      logic signed [PRI_W-1:0]   top_priority;
   } pq_result;

   // Shadow copy of the stored entries and the responses still owed
   class priority_checker;
      entry_type  held[$];
      pq_result   awaited[$];
      int         error_count;

      function void report_mismatch(string what);
         error_count++;
         if (error_count <= PRINT_LIMIT) begin
            $display("mismatch: %s", what);
         end
      endfunction

      // Higher priority wins, then the larger value
      function bit serves_first(entry_type a, entry_type b);
         if (a.prio != b.prio) begin
            return a.prio > b.prio;
         end
         return a.value > b.value;
      endfunction

      function int top_slot();
         int best = 0;
         for (int i = 1; i < held.size(); i++) begin
            if (serves_first(held[i], held[best])) begin
               best = i;
            end
         end
         return best;
      endfunction

      // Apply one accepted request to the shadow and queue its response
      function void note_request(op_type op, entry_type e);
         pq_result r;
         int       t;
         r = '0;
         r.status = STATUS_OK;
         if (op == OP_INSERT) begin
            if (held.size() >= CAPACITY) begin
               r.status = STATUS_FULL;
            end else begin
               held.push_back(e);
            end
         end else if (held.size() == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            t = top_slot();
            r.removed_value = held[t].value;
            r.removed_priority = held[t].prio;
            held.delete(t);
         end
         r.count_after = CNT_W'(held.size());
         if (held.size() > 0) begin
            t = top_slot();
            r.top_valid = 1'b1;
            r.top_value = held[t].value;
            r.top_priority = held[t].prio;
         end
         awaited.push_back(r);
      endfunction

      function void check_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want) begin
            report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
         end
      endfunction

      // Compare a delivered response with the oldest one owed
      function void check_result(pq_result got);
         pq_result want;
         if (awaited.size() == 0) begin
            report_mismatch("response with no request outstanding");
            return;
         end
         want = awaited.pop_front();
         check_field("status", got.status, want.status);
         check_field("removed_value", got.removed_value, want.removed_value);
         check_field("removed_priority", got.removed_priority, want.removed_priority);
         check_field("count_after", got.count_after, want.count_after);
         check_field("top_valid", got.top_valid, want.top_valid);
         check_field("top_value", got.top_value, want.top_value);
         check_field("top_priority", got.top_priority, want.top_priority);
      endfunction
   endclass

   logic clock;
   logic reset;

   apq_req_if req_ch ();
   apq_rsp_if rsp_ch ();

   array_priority_queue i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   priority_checker book = new();

   int tx_idle_pct = 37;
   int rx_idle_pct = 78;
   int sent = 0;
   int gen_count = 0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Give up after a generous fixed time
   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   // Stall the response channel at random
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // Note accepted requests, check accepted responses
   always @(posedge clock) begin
      entry_type taken;
      pq_result  got;
      if (!reset && req_ch.valid && req_ch.ready) begin
         taken.value = req_ch.entry_value;
         taken.prio = req_ch.entry_priority;
         book.note_request(op_type'(req_ch.opcode), taken);
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.status = status_type'(rsp_ch.status);
         got.removed_value = rsp_ch.removed_value;
         got.removed_priority = rsp_ch.removed_priority;
         got.count_after = rsp_ch.count_after;
         got.top_valid = rsp_ch.top_valid;
         got.top_value = rsp_ch.top_value;
         got.top_priority = rsp_ch.top_priority;
         book.check_result(got);
      end
   end

   // Values: full range, or a narrow set that forces ties and extremes
   function automatic logic signed [VAL_W-1:0] pick_value(bit narrow);
      logic signed [VAL_W-1:0] v;
      if (!narrow) begin
         v = $urandom();
      end else begin
         case ($urandom_range(5))
            0: v = 32'sh8000_0000;
            1: v = 32'sh7fff_ffff;
            2: v = '0;
            3: v = -1;
            default: v = int'($urandom_range(6)) - 3;
         endcase
      end
      return v;
   endfunction

   function automatic logic signed [PRI_W-1:0] pick_priority(bit narrow);
      logic signed [PRI_W-1:0] p;
      if (!narrow) begin
         p = PRI_W'($urandom());
      end else begin
         case ($urandom_range(5))
            0: p = 16'sh8000;
            1: p = 16'sh7fff;
            2: p = '0;
            3: p = PRI_W'(-1);
            default: p = PRI_W'(int'($urandom_range(4)) - 2);
         endcase
      end
      return p;
   endfunction

   // Drive one request and hold it until accepted
   task automatic send_request(input op_type op, input logic signed [VAL_W-1:0] val,
                               input logic signed [PRI_W-1:0] pri);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.entry_value <= val;
      req_ch.entry_priority <= pri;
      do @(posedge clock); while (!req_ch.ready);
      sent++;
      if (op == OP_INSERT && gen_count < CAPACITY) begin
         gen_count++;
      end else if (op == OP_REMOVE && gen_count > 0) begin
         gen_count--;
      end
   endtask

   task automatic send_remove();
      send_request(OP_REMOVE, $urandom(), PRI_W'($urandom()));
   endtask

   // Empty queue, lowest priority, ties on priority, duplicates, extremes
   task automatic run_directed();
      send_remove();
      send_request(OP_INSERT, '0, 16'sh8000);
      send_remove();
      send_remove();
      send_request(OP_INSERT, 32'sh7fff_ffff, 16'sh7fff);
      send_request(OP_INSERT, 32'sh8000_0000, 16'sh7fff);
      send_request(OP_INSERT, -1, 16'sh8000);
      send_request(OP_INSERT, 5, 16'sd100);
      send_request(OP_INSERT, 5, 16'sd100);
      send_request(OP_INSERT, -5, 16'sd100);
      send_request(OP_INSERT, 32'sh8000_0000, 16'sh8000);
      repeat (8) send_remove();
   endtask

   // One burst of random requests, half of them shaped to reach full and empty
   task automatic run_burst();
      int  kind;
      int  len;
      int  insert_pct;
      bit  narrow;
      kind = $urandom_range(9);
      narrow = 1'($urandom_range(1));
      if (kind <= 2) begin
         // fill to capacity, then push against the full queue
         while (gen_count < CAPACITY) begin
            send_request(OP_INSERT, pick_value(narrow), pick_priority(narrow));
         end
         repeat ($urandom_range(3, 1)) begin
            send_request(OP_INSERT, pick_value(narrow), pick_priority(narrow));
         end
      end else if (kind <= 4) begin
         // drain to empty, then remove once or twice more
         while (gen_count > 0) send_remove();
         repeat ($urandom_range(2, 1)) send_remove();
      end else if (kind <= 8) begin
         // mixed traffic; the narrow sets make ties common
         len = $urandom_range(60, 10);
         insert_pct = $urandom_range(70, 30);
         if (kind == 8) begin
            narrow = 1'b1;
         end
         repeat (len) begin
            if ($urandom_range(99) < insert_pct) begin
               send_request(OP_INSERT, pick_value(narrow), pick_priority(narrow));
            end else begin
               send_remove();
            end
         end
      end else begin
         // noise: fully random fields and operations
         repeat ($urandom_range(20, 5)) begin
            send_request(op_type'($urandom_range(1)), $urandom(), PRI_W'($urandom()));
         end
      end
   endtask

   // Reset, directed tests, three idling phases, drain, verdict
   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_INSERT;
      req_ch.entry_value = '0;
      req_ch.entry_priority = '0;
      rsp_ch.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               tx_idle_pct = 37;
               rx_idle_pct = 78;
            end
            1: begin
               tx_idle_pct = 78;
               rx_idle_pct = 37;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         if (ph == 0) begin
            run_directed();
         end
         while (sent < (ph + 1) * ITEM_TARGET / 3) run_burst();
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (book.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (book.error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
